// ===== design/rpc_frame_deframer_macros.svh =====
// ----------------------------------------------------------------------------
// Frame deframer assertion macros
// Concurrent assertion helpers clocked by clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RPC_FRAME_DEFRAMER_MACROS_SVH
`define RPC_FRAME_DEFRAMER_MACROS_SVH

`ifndef ASSERT_OFF

// The property must hold at every clock edge outside reset.
`define RFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("rpc_frame_deframer assertion failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define RFD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpc_frame_deframer assertion failed");

`else

`define RFD_ASSERT(lbl, prop)
`define RFD_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== design/rfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rfd_pkg
// Header layout, result codes, error codes and register indexes of the
// frame deframer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rfd_pkg;

  // Header layout: big-endian fields at fixed byte offsets.
  localparam int unsigned HEADER_BYTES   = 28;
  localparam int unsigned HDR_BITS       = 8 * HEADER_BYTES;
  localparam int unsigned HDR_STORE_BITS = 8 * (HEADER_BYTES - 1);
  localparam int unsigned HDR_CNT_W      = 5;

  localparam int unsigned OFS_MAGIC    = 0;
  localparam int unsigned OFS_VERSION  = 4;
  localparam int unsigned OFS_HDR_LEN  = 6;
  localparam int unsigned OFS_BODY_LEN = 8;
  localparam int unsigned OFS_REQ_ID   = 12;
  localparam int unsigned OFS_MSG_TYPE = 20;
  localparam int unsigned OFS_STATUS   = 22;
  localparam int unsigned OFS_CHECKSUM = 24;

  localparam logic [HDR_CNT_W-1:0] HDR_LAST_IDX = HDR_CNT_W'(HEADER_BYTES - 1);
  localparam logic [15:0]          HDR_LEN_EXP  = 16'(HEADER_BYTES);

  // Result kinds.
  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_BODY   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_OK        = 3'd0;
  localparam logic [2:0] ERR_MAGIC     = 3'd1;
  localparam logic [2:0] ERR_VERSION   = 3'd2;
  localparam logic [2:0] ERR_FRAME     = 3'd3;
  localparam logic [2:0] ERR_TOO_LARGE = 3'd4;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERSION   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BODY  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_TYPE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RSP_TYPE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HB_TYPE   = 3'd5;

  // Configuration reset values.
  localparam logic [31:0] MAGIC_RST    = 32'd0;
  localparam logic [15:0] VERSION_RST  = 16'd0;
  localparam logic [31:0] MAX_BODY_RST = 32'd65536;
  localparam logic [15:0] REQ_TYPE_RST = 16'd1;
  localparam logic [15:0] RSP_TYPE_RST = 16'd2;
  localparam logic [15:0] HB_TYPE_RST  = 16'd3;

endpackage

`default_nettype wire

// ===== design/rpc_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// rpc_frame_deframer
// Parses a length-prefixed frame stream: collects the 28-byte header, checks
// it against the configured values and passes the body bytes on.
// ----------------------------------------------------------------------------
// The block takes one stream byte per clock cycle unless stalled. Each byte is
// fully handled in the cycle it is accepted, and its result (if any) lands in
// a single output register. Header bytes other than the last produce no
// result and are accepted even while the output is stalled; a byte that
// produces a result (the last header byte or a body byte) is held off only
// when the output register is full and stalled in that same cycle, so the
// output register throughput of one transaction per cycle sets the rate.
// The header is held in a byte shift line, so there is no clearing pass
// after reset.
`timescale 1ns / 1ps
`default_nettype none

`include "rpc_frame_deframer_macros.svh"

module rpc_frame_deframer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Configuration write port
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_wdata_i,
  // Byte stream in
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  stream_byte_i,
  // Results out
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       result_kind_o,
  output logic [2:0]       error_code_o,
  output logic [63:0]      request_id_o,
  output logic [15:0]      message_type_o,
  output logic [15:0]      status_field_o,
  output logic [31:0]      checksum_field_o,
  output logic [31:0]      body_length_o,
  output logic [7:0]       body_byte_o,
  output logic             last_o
);

  import rfd_pkg::*;

  // Configuration registers.
  logic [31:0] magic_q;
  logic [15:0] version_q;
  logic [31:0] max_body_q;
  logic [15:0] req_type_q;
  logic [15:0] rsp_type_q;
  logic [15:0] hb_type_q;

  // Parser state.
  logic                      phase_q;
  logic [HDR_CNT_W-1:0]      hdr_cnt_q;
  logic [HDR_STORE_BITS-1:0] hdr_q;
  logic [31:0]               body_rem_q;

  // Output register.
  logic        out_valid_q;
  logic [1:0]  kind_q;
  logic [2:0]  err_q;
  logic [63:0] rid_q;
  logic [15:0] mtype_q;
  logic [15:0] stat_q;
  logic [31:0] csum_q;
  logic [31:0] blen_q;
  logic [7:0]  bbyte_q;
  logic        last_q;

  logic        hdr_last;
  logic        emit;
  logic        in_acc;

  logic [HDR_BITS-1:0] hdr_full;
  logic [31:0] f_magic;
  logic [15:0] f_version;
  logic [15:0] f_hdr_len;
  logic [31:0] f_body_len;
  logic [63:0] f_req_id;
  logic [15:0] f_msg_type;
  logic [15:0] f_status;
  logic [31:0] f_checksum;
  logic [2:0]  hdr_err;
  logic [31:0] body_rem_dec;

  logic        phase_d;
  logic [HDR_CNT_W-1:0] hdr_cnt_d;
  logic [31:0] body_rem_d;
  logic        out_valid_d;
  logic [1:0]  kind_d;
  logic [2:0]  err_d;
  logic [63:0] rid_d;
  logic [15:0] mtype_d;
  logic [15:0] stat_d;
  logic [31:0] csum_d;
  logic [31:0] blen_d;
  logic [7:0]  bbyte_d;
  logic        last_d;

  // Whether the byte offered now produces a result depends on state only.
  assign hdr_last   = !phase_q && (hdr_cnt_q == HDR_LAST_IDX);
  assign emit       = phase_q || hdr_last;
  assign in_stall_o = out_valid_q && out_stall_i && emit;
  assign in_acc     = in_valid_i && !in_stall_o;

  // The full header is the shift line plus the byte arriving now.
  assign hdr_full   = {hdr_q, stream_byte_i};
  assign f_magic    = hdr_full[HDR_BITS-1-8*OFS_MAGIC    -: 32];
  assign f_version  = hdr_full[HDR_BITS-1-8*OFS_VERSION  -: 16];
  assign f_hdr_len  = hdr_full[HDR_BITS-1-8*OFS_HDR_LEN  -: 16];
  assign f_body_len = hdr_full[HDR_BITS-1-8*OFS_BODY_LEN -: 32];
  assign f_req_id   = hdr_full[HDR_BITS-1-8*OFS_REQ_ID   -: 64];
  assign f_msg_type = hdr_full[HDR_BITS-1-8*OFS_MSG_TYPE -: 16];
  assign f_status   = hdr_full[HDR_BITS-1-8*OFS_STATUS   -: 16];
  assign f_checksum = hdr_full[HDR_BITS-1-8*OFS_CHECKSUM -: 32];

  // The first failing check wins.
  always_comb begin
    if (f_magic != magic_q) begin
      hdr_err = ERR_MAGIC;
    end else if (f_version != version_q) begin
      hdr_err = ERR_VERSION;
    end else if (f_hdr_len != HDR_LEN_EXP) begin
      hdr_err = ERR_FRAME;
    end else if (f_body_len > max_body_q) begin
      hdr_err = ERR_TOO_LARGE;
    end else if ((f_msg_type != req_type_q) && (f_msg_type != rsp_type_q) &&
                 (f_msg_type != hb_type_q)) begin
      hdr_err = ERR_FRAME;
    end else begin
      hdr_err = ERR_OK;
    end
  end

  assign body_rem_dec = (body_rem_q != 32'd0) ? (body_rem_q - 32'd1) : 32'd0;

  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    body_rem_d  = body_rem_q;
    out_valid_d = out_valid_q && out_stall_i;
    kind_d      = kind_q;
    err_d       = err_q;
    rid_d       = rid_q;
    mtype_d     = mtype_q;
    stat_d      = stat_q;
    csum_d      = csum_q;
    blen_d      = blen_q;
    bbyte_d     = bbyte_q;
    last_d      = last_q;

    if (in_acc) begin
      if (phase_q) begin
        body_rem_d  = body_rem_dec;
        out_valid_d = 1'b1;
        kind_d      = KIND_BODY;
        err_d       = ERR_OK;
        rid_d       = 64'd0;
        mtype_d     = 16'd0;
        stat_d      = 16'd0;
        csum_d      = 32'd0;
        blen_d      = 32'd0;
        bbyte_d     = stream_byte_i;
        last_d      = (body_rem_dec == 32'd0);
        if (body_rem_dec == 32'd0) begin
          phase_d = 1'b0;
        end
      end else if (hdr_last) begin
        hdr_cnt_d   = '0;
        out_valid_d = 1'b1;
        err_d       = hdr_err;
        rid_d       = f_req_id;
        mtype_d     = f_msg_type;
        stat_d      = f_status;
        csum_d      = f_checksum;
        blen_d      = f_body_len;
        bbyte_d     = 8'd0;
        if (hdr_err != ERR_OK) begin
          kind_d = KIND_REJECT;
          last_d = 1'b1;
        end else begin
          kind_d = KIND_HEADER;
          last_d = (f_body_len == 32'd0);
          if (f_body_len != 32'd0) begin
            body_rem_d = f_body_len;
            phase_d    = 1'b1;
          end
        end
      end else begin
        hdr_cnt_d = hdr_cnt_q + HDR_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q    <= MAGIC_RST;
      version_q  <= VERSION_RST;
      max_body_q <= MAX_BODY_RST;
      req_type_q <= REQ_TYPE_RST;
      rsp_type_q <= RSP_TYPE_RST;
      hb_type_q  <= HB_TYPE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_MAGIC:    magic_q    <= cfg_wdata_i;
        REG_VERSION:  version_q  <= cfg_wdata_i[15:0];
        REG_MAX_BODY: max_body_q <= cfg_wdata_i;
        REG_REQ_TYPE: req_type_q <= cfg_wdata_i[15:0];
        REG_RSP_TYPE: rsp_type_q <= cfg_wdata_i[15:0];
        REG_HB_TYPE:  hb_type_q  <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= 1'b0;
      hdr_cnt_q   <= '0;
      body_rem_q  <= 32'd0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      body_rem_q  <= body_rem_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Header shift line and result payload carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc && !phase_q && !hdr_last) begin
      hdr_q <= {hdr_q[HDR_STORE_BITS-9:0], stream_byte_i};
    end
    kind_q  <= kind_d;
    err_q   <= err_d;
    rid_q   <= rid_d;
    mtype_q <= mtype_d;
    stat_q  <= stat_d;
    csum_q  <= csum_d;
    blen_q  <= blen_d;
    bbyte_q <= bbyte_d;
    last_q  <= last_d;
  end

  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = kind_q;
  assign error_code_o     = err_q;
  assign request_id_o     = rid_q;
  assign message_type_o   = mtype_q;
  assign status_field_o   = stat_q;
  assign checksum_field_o = csum_q;
  assign body_length_o    = blen_q;
  assign body_byte_o      = bbyte_q;
  assign last_o           = last_q;

  // While passing body bytes, no header collection is in progress and
  // there is always at least one byte left.
  `RFD_ASSERT(a_body_no_hdr, !phase_q || ((hdr_cnt_q == '0) && (body_rem_q != 32'd0)))

  // A rejected header always closes its transaction with an error code.
  `RFD_ASSERT(a_reject_last, !(out_valid_q && (kind_q == KIND_REJECT)) || (last_q && (err_q != ERR_OK)))

  // The final body byte returns the parser to header collection.
  `RFD_ASSERT_NEXT(a_body_end, in_acc && phase_q && (body_rem_q == 32'd1), !phase_q && out_valid_q && last_q)

  // The last header byte always produces a result and rewinds the count.
  `RFD_ASSERT_NEXT(a_hdr_wrap, in_acc && hdr_last, out_valid_q && (hdr_cnt_q == '0))

  // An accepted body byte is never a header or rejection result.
  `RFD_ASSERT_NEXT(a_body_kind, in_acc && phase_q, out_valid_q && (kind_q == KIND_BODY))

endmodule

`default_nettype wire
